[hw/rtl/tshc_pkg.sv]
package tshc_pkg;

  localparam int ADC_WIDTH_DEF = 20;
  localparam int LN_DEPTH_DEF  = 64;

  localparam int CODE_FIELD_W = 20;
  localparam int VOLT_W       = 20;
  localparam int BIAS_W       = 14;
  localparam int COEF_W       = 48;
  localparam int TEMP_W       = 24;
  localparam int DEN_W        = 24;
  localparam int TAB_W        = 30;
  localparam int LN_W         = 36;
  localparam int MAG_W        = 48;
  localparam int HALF_W       = 24;
  localparam int SUM_W        = 63;
  localparam int DIV_W        = 62;
  localparam int QUO_W        = 24;

  localparam logic [VOLT_W-1:0]  VOLT_RST = 20'd2000;
  localparam logic [BIAS_W-1:0]  BIAS_RST = 14'd50;
  localparam logic [COEF_W-1:0]  COEF_A_RST = 48'sd1118622899085;
  localparam logic [COEF_W-1:0]  COEF_B_RST = -48'sd155525673459;
  localparam logic [COEF_W-1:0]  COEF_C_RST = 48'sd476466767;

  localparam logic [9:0]         MICRO_PER_MILLI = 10'd1000;
  localparam logic [29:0]        LN2_Q30   = 30'd744261118;
  localparam logic [61:0]        CLAMP_LIM = 62'h2000_0000_0000_0000;
  localparam logic [DIV_W-1:0]   KELVIN100 = DIV_W'(64'd100 << 44);
  localparam logic [QUO_W-1:0]   ZERO_C_CENTI = 24'd27315;
  localparam logic [QUO_W-1:0]   CK_MAX    = 24'd8415922;
  localparam logic [TEMP_W-1:0]  TEMP_MAX  = 24'h7fffff;

  typedef enum logic [1:0] {
    STATUS_OK   = 2'd0,
    STATUS_ZERO = 2'd1,
    STATUS_SAT  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    REG_VOLT   = 3'd0,
    REG_BIAS   = 3'd1,
    REG_COEF_A = 3'd2,
    REG_COEF_B = 3'd3,
    REG_COEF_C = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [MAG_W-1:0] p11;
    logic [MAG_W-1:0] p10;
    logic [MAG_W-1:0] p01;
    logic [MAG_W-1:0] p00;
  } pp_t;

  // series term divided by the odd number 2j+1
  function automatic logic [63:0] odd_div(input logic [63:0] t, input int j);
    logic [63:0] r;
    case (j)
      0:  r = t;
      1:  r = t / 3;
      2:  r = t / 5;
      3:  r = t / 7;
      4:  r = t / 9;
      5:  r = t / 11;
      6:  r = t / 13;
      7:  r = t / 15;
      8:  r = t / 17;
      9:  r = t / 19;
      10: r = t / 21;
      11: r = t / 23;
      12: r = t / 25;
      13: r = t / 27;
      14: r = t / 29;
      15: r = t / 31;
      default: r = '0;
    endcase
    return r;
  endfunction

  // 2*atanh(z), z in q30, truncated series
  function automatic logic [TAB_W-1:0] ln_series(input logic [63:0] z);
    logic [63:0] z2;
    logic [63:0] term;
    logic [63:0] sum;
    z2   = (z * z) >> 30;
    term = z;
    sum  = '0;
    for (int j = 0; j < 16; j++) begin
      if (term != 0) begin
        sum  = sum + odd_div(term, j);
        term = (term * z2) >> 30;
      end
    end
    return TAB_W'(sum << 1);
  endfunction

  function automatic logic [MAG_W-1:0] mag48(input logic [COEF_W-1:0] v);
    return v[COEF_W-1] ? MAG_W'(-v) : MAG_W'(v);
  endfunction

  function automatic pp_t mul_pp(input logic [MAG_W-1:0] a, input logic [MAG_W-1:0] b);
    pp_t r;
    r.p11 = MAG_W'(a[MAG_W-1:HALF_W]) * MAG_W'(b[MAG_W-1:HALF_W]);
    r.p10 = MAG_W'(a[MAG_W-1:HALF_W]) * MAG_W'(b[HALF_W-1:0]);
    r.p01 = MAG_W'(a[HALF_W-1:0]) * MAG_W'(b[MAG_W-1:HALF_W]);
    r.p00 = MAG_W'(a[HALF_W-1:0]) * MAG_W'(b[HALF_W-1:0]);
    return r;
  endfunction

  // sum partial products, drop 30 fraction bits, clamp, apply sign
  function automatic logic signed [SUM_W-1:0] mul_fin(input pp_t pp, input logic neg);
    logic [95:0] full;
    logic [65:0] sh;
    logic [SUM_W-1:0] m;
    full = {pp.p11, 48'd0} + {24'd0, pp.p10, 24'd0} + {24'd0, pp.p01, 24'd0}
         + {48'd0, pp.p00};
    sh = full[95:30];
    m  = (sh > 66'(CLAMP_LIM)) ? SUM_W'(CLAMP_LIM) : SUM_W'(sh);
    return neg ? -$signed(m) : $signed(m);
  endfunction

  function automatic logic signed [SUM_W-1:0] clamp61(input logic signed [63:0] v);
    logic signed [SUM_W-1:0] r;
    if (v > $signed({2'b00, CLAMP_LIM}))
      r = $signed({1'b0, CLAMP_LIM});
    else if (v < -$signed({2'b00, CLAMP_LIM}))
      r = -$signed({1'b0, CLAMP_LIM});
    else
      r = SUM_W'(v);
    return r;
  endfunction

endpackage

[hw/rtl/thermistor_steinhart_hart_converter.sv]
// channel   dir  signals                         content
// s_*       in   s_tvalid s_tready s_tdata      raw adc code
// m_*       out  m_tvalid m_tready m_tdata      temperature and status
// cfg_*     in   cfg_we cfg_index cfg_data      coefficient and scale writes
//
// one code accepted per cycle while m_tready does not stall the output; results leave in order
// pipeline depth is set by the 24 restoring divide steps and the split 48x48 multiplies
// each stage holds only when the stage after it is full and held (the last when m_tready is low), so bubbles collapse
// rst is synchronous; it clears valid bits and loads register defaults, no clearing pass
module thermistor_steinhart_hart_converter #(
  parameter int ADC_WIDTH      = tshc_pkg::ADC_WIDTH_DEF,
  parameter int LN_TABLE_DEPTH = tshc_pkg::LN_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // [19:0] raw_code
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [23:0] temp_centi_c, [25:24] status
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [47:0] cfg_data
);

  localparam int CODE_W = (ADC_WIDTH < tshc_pkg::CODE_FIELD_W) ? ADC_WIDTH
                                                               : tshc_pkg::CODE_FIELD_W;
  localparam int NUM_W  = CODE_W + tshc_pkg::VOLT_W;
  localparam int PN_W   = $clog2(NUM_W);
  localparam int PD_W   = $clog2(tshc_pkg::DEN_W);
  localparam int K_W    = $clog2(LN_TABLE_DEPTH);
  localparam int IDX_W  = $clog2(LN_TABLE_DEPTH + 1);
  localparam int SC_W   = 32 + IDX_W;
  localparam int DIV_N  = tshc_pkg::QUO_W;
  localparam int ST_DIV = 16;
  localparam int N_ST   = ST_DIV + DIV_N + 1;
  localparam int CMP_W  = tshc_pkg::DIV_W + DIV_N;

  localparam int TAB_W  = tshc_pkg::TAB_W;
  localparam int LN_W   = tshc_pkg::LN_W;
  localparam int SUM_W  = tshc_pkg::SUM_W;
  localparam int MAG_W  = tshc_pkg::MAG_W;
  localparam int DIV_W  = tshc_pkg::DIV_W;

  // configuration registers
  logic [tshc_pkg::VOLT_W-1:0] volt_per_lsb_nv;
  logic [tshc_pkg::BIAS_W-1:0] bias_current_ua;
  logic [tshc_pkg::COEF_W-1:0] coef_a;
  logic [tshc_pkg::COEF_W-1:0] coef_b;
  logic [tshc_pkg::COEF_W-1:0] coef_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      volt_per_lsb_nv <= tshc_pkg::VOLT_RST;
      bias_current_ua <= tshc_pkg::BIAS_RST;
      coef_a          <= tshc_pkg::COEF_A_RST;
      coef_b          <= tshc_pkg::COEF_B_RST;
      coef_c          <= tshc_pkg::COEF_C_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tshc_pkg::REG_VOLT:   volt_per_lsb_nv <= cfg_data[tshc_pkg::VOLT_W-1:0];
        tshc_pkg::REG_BIAS:   bias_current_ua <= cfg_data[tshc_pkg::BIAS_W-1:0];
        tshc_pkg::REG_COEF_A: coef_a <= cfg_data;
        tshc_pkg::REG_COEF_B: coef_b <= cfg_data;
        tshc_pkg::REG_COEF_C: coef_c <= cfg_data;
        default: ;
      endcase
    end
  end

  // log table ln(1 + k/depth) in q30
  logic [TAB_W-1:0] ln_tab [LN_TABLE_DEPTH+1];
  for (genvar g = 0; g <= LN_TABLE_DEPTH; g++) begin : g_tab
    localparam logic [63:0] Z = (64'(g) << 30) / 64'(2 * LN_TABLE_DEPTH + g);
    assign ln_tab[g] = tshc_pkg::ln_series(Z);
  end

  // valid bits and per-stage load enables
  logic [N_ST:1]   v;
  logic [N_ST:1]   v_prev;
  logic [N_ST+1:1] en;

  assign v_prev = {v[N_ST-1:1], s_tvalid};
  always_comb begin
    en[N_ST+1] = m_tready;
    for (int i = N_ST; i >= 1; i--)
      en[i] = !v[i] || en[i+1];
  end
  assign s_tready = en[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      for (int i = 1; i <= N_ST; i++)
        if (en[i]) v[i] <= v_prev[i];
    end
  end

  // stage 1: voltage and bias products
  logic [NUM_W-1:0]          num1;
  logic [tshc_pkg::DEN_W-1:0] den1;
  logic [CODE_W-1:0]         code;
  logic [tshc_pkg::BIAS_W-1:0] bias_eff;

  assign code     = s_tdata[CODE_W-1:0];
  assign bias_eff = (bias_current_ua == '0) ? tshc_pkg::BIAS_W'(1) : bias_current_ua;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      num1 <= NUM_W'(code) * NUM_W'(volt_per_lsb_nv);
      den1 <= tshc_pkg::DEN_W'(bias_eff) * tshc_pkg::DEN_W'(tshc_pkg::MICRO_PER_MILLI);
    end
  end

  // stage 2: leading one positions
  logic [PN_W-1:0] pn_c;
  logic [PD_W-1:0] pd_c;
  logic [NUM_W-1:0] num2;
  logic [tshc_pkg::DEN_W-1:0] den2;
  logic [PN_W-1:0] pn2;
  logic [PD_W-1:0] pd2;
  logic zr2;

  always_comb begin
    pn_c = '0;
    for (int b = 0; b < NUM_W; b++)
      if (num1[b]) pn_c = PN_W'(b);
    pd_c = '0;
    for (int b = 0; b < tshc_pkg::DEN_W; b++)
      if (den1[b]) pd_c = PD_W'(b);
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      num2 <= num1;
      den2 <= den1;
      pn2  <= pn_c;
      pd2  <= pd_c;
      zr2  <= (num1 == '0);
    end
  end

  // stage 3: bits below the leading one, aligned to 32
  logic [NUM_W+31:0] fn_sh;
  logic [tshc_pkg::DEN_W+31:0] fd_sh;
  logic [31:0] fn3, fd3;
  logic [PN_W-1:0] pn3;
  logic [PD_W-1:0] pd3;
  logic zr3;

  assign fn_sh = {num2, 32'd0} >> pn2;
  assign fd_sh = {den2, 32'd0} >> pd2;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      fn3 <= fn_sh[31:0];
      fd3 <= fd_sh[31:0];
      pn3 <= pn2;
      pd3 <= pd2;
      zr3 <= zr2;
    end
  end

  // stage 4: table index and interpolation fraction
  logic [SC_W-1:0] scn, scd;
  logic [K_W-1:0] kn4, kd4;
  logic [31:0] rn4, rd4;
  logic [PN_W-1:0] pn4;
  logic [PD_W-1:0] pd4;
  logic zr4;

  assign scn = SC_W'(fn3) * SC_W'(LN_TABLE_DEPTH);
  assign scd = SC_W'(fd3) * SC_W'(LN_TABLE_DEPTH);

  always_ff @(posedge clk) begin
    if (en[4]) begin
      kn4 <= scn[32 +: K_W];
      kd4 <= scd[32 +: K_W];
      rn4 <= scn[31:0];
      rd4 <= scd[31:0];
      pn4 <= pn3;
      pd4 <= pd3;
      zr4 <= zr3;
    end
  end

  // stage 5: table reads
  logic [IDX_W-1:0] in_lo, id_lo;
  logic [TAB_W-1:0] lon5, lod5, dfn5, dfd5;
  logic [31:0] rn5, rd5;
  logic [PN_W-1:0] pn5;
  logic [PD_W-1:0] pd5;
  logic zr5;

  assign in_lo = IDX_W'(kn4);
  assign id_lo = IDX_W'(kd4);

  always_ff @(posedge clk) begin
    if (en[5]) begin
      lon5 <= ln_tab[in_lo];
      lod5 <= ln_tab[id_lo];
      dfn5 <= ln_tab[in_lo + IDX_W'(1)] - ln_tab[in_lo];
      dfd5 <= ln_tab[id_lo + IDX_W'(1)] - ln_tab[id_lo];
      rn5  <= rn4;
      rd5  <= rd4;
      pn5  <= pn4;
      pd5  <= pd4;
      zr5  <= zr4;
    end
  end

  // stage 6: interpolation product
  logic [TAB_W+31:0] ipn, ipd;
  logic [TAB_W-1:0] lon6, lod6, frn6, frd6;
  logic [PN_W-1:0] pn6;
  logic [PD_W-1:0] pd6;
  logic zr6;

  assign ipn = (TAB_W + 32)'(dfn5) * (TAB_W + 32)'(rn5);
  assign ipd = (TAB_W + 32)'(dfd5) * (TAB_W + 32)'(rd5);

  always_ff @(posedge clk) begin
    if (en[6]) begin
      frn6 <= ipn[TAB_W+31:32];
      frd6 <= ipd[TAB_W+31:32];
      lon6 <= lon5;
      lod6 <= lod5;
      pn6  <= pn5;
      pd6  <= pd5;
      zr6  <= zr5;
    end
  end

  // stage 7: logs
  logic [LN_W-1:0] lnn7, lnd7;
  logic zr7;

  always_ff @(posedge clk) begin
    if (en[7]) begin
      lnn7 <= LN_W'(pn6) * LN_W'(tshc_pkg::LN2_Q30) + LN_W'(lon6) + LN_W'(frn6);
      lnd7 <= LN_W'(pd6) * LN_W'(tshc_pkg::LN2_Q30) + LN_W'(lod6) + LN_W'(frd6);
      zr7  <= zr6;
    end
  end

  // stage 8: ln r as sign and magnitude
  logic [LN_W:0] ldiff;
  logic lsg8;
  logic [LN_W-1:0] lmg8;
  logic zr8;

  assign ldiff = {1'b0, lnn7} - {1'b0, lnd7};

  always_ff @(posedge clk) begin
    if (en[8]) begin
      lsg8 <= ldiff[LN_W];
      lmg8 <= ldiff[LN_W] ? LN_W'(-ldiff) : ldiff[LN_W-1:0];
      zr8  <= zr7;
    end
  end

  // stages 9, 10: ln^2 and b*ln
  tshc_pkg::pp_t ppll9, ppbl9;
  logic nbl9, lsg9, zr9;
  logic [LN_W-1:0] lmg9;
  logic signed [SUM_W-1:0] l2_10, bl10;
  logic lsg10, zr10;
  logic [LN_W-1:0] lmg10;

  always_ff @(posedge clk) begin
    if (en[9]) begin
      ppll9 <= tshc_pkg::mul_pp(MAG_W'(lmg8), MAG_W'(lmg8));
      ppbl9 <= tshc_pkg::mul_pp(tshc_pkg::mag48(coef_b), MAG_W'(lmg8));
      nbl9  <= coef_b[tshc_pkg::COEF_W-1] ^ lsg8;
      lsg9  <= lsg8;
      lmg9  <= lmg8;
      zr9   <= zr8;
    end
    if (en[10]) begin
      l2_10 <= tshc_pkg::mul_fin(ppll9, 1'b0);
      bl10  <= tshc_pkg::mul_fin(ppbl9, nbl9);
      lsg10 <= lsg9;
      lmg10 <= lmg9;
      zr10  <= zr9;
    end
  end

  // stages 11, 12: ln^3 and a + b*ln
  tshc_pkg::pp_t pp3_11;
  logic lsg11, zr11, zr12;
  logic signed [SUM_W-1:0] s1_11, s1_12, l3_12;

  always_ff @(posedge clk) begin
    if (en[11]) begin
      pp3_11 <= tshc_pkg::mul_pp(l2_10[MAG_W-1:0], MAG_W'(lmg10));
      s1_11  <= tshc_pkg::clamp61(64'($signed(coef_a)) + 64'(bl10));
      lsg11  <= lsg10;
      zr11   <= zr10;
    end
    if (en[12]) begin
      l3_12 <= tshc_pkg::mul_fin(pp3_11, lsg11);
      s1_12 <= s1_11;
      zr12  <= zr11;
    end
  end

  // stages 13, 14: c*ln^3
  logic [SUM_W-1:0] l3abs;
  tshc_pkg::pp_t ppc13;
  logic nc13, zr13, zr14;
  logic signed [SUM_W-1:0] s1_13, s1_14, cl14;

  assign l3abs = l3_12[SUM_W-1] ? SUM_W'(-l3_12) : SUM_W'(l3_12);

  always_ff @(posedge clk) begin
    if (en[13]) begin
      ppc13 <= tshc_pkg::mul_pp(tshc_pkg::mag48(coef_c), l3abs[MAG_W-1:0]);
      nc13  <= coef_c[tshc_pkg::COEF_W-1] ^ l3_12[SUM_W-1];
      s1_13 <= s1_12;
      zr13  <= zr12;
    end
    if (en[14]) begin
      cl14  <= tshc_pkg::mul_fin(ppc13, nc13);
      s1_14 <= s1_13;
      zr14  <= zr13;
    end
  end

  // stage 15: full sum 1/t
  logic signed [SUM_W-1:0] s15;
  logic zr15;

  always_ff @(posedge clk) begin
    if (en[15]) begin
      s15  <= tshc_pkg::clamp61(64'(s1_14) + 64'(cl14));
      zr15 <= zr14;
    end
  end

  // stage 16 and divide steps: kelvin*100 = round((100<<44)/s)
  logic [DIV_W-1:0] sp;
  logic [DIV_W-1:0] nmr;

  assign sp  = s15[DIV_W-1:0];
  assign nmr = tshc_pkg::KELVIN100 + (sp >> 1);

  logic [DIV_W-1:0] dv_s   [DIV_N+1];
  logic [DIV_W-1:0] dv_rem [DIV_N+1];
  logic [DIV_N-1:0] dv_q   [DIV_N+1];
  logic             dv_zr  [DIV_N+1];
  logic             dv_sat [DIV_N+1];

  always_ff @(posedge clk) begin
    if (en[ST_DIV]) begin
      dv_s[0]   <= sp;
      dv_rem[0] <= nmr;
      dv_q[0]   <= '0;
      dv_zr[0]  <= zr15;
      // non-positive sum, or quotient too wide for the result
      dv_sat[0] <= (s15 <= 0) || ({DIV_N'(0), nmr} >= {sp, DIV_N'(0)});
    end
  end

  for (genvar j = 0; j < DIV_N; j++) begin : g_div
    localparam int B = DIV_N - 1 - j;
    logic [CMP_W-1:0] trial;
    logic             take;
    assign trial = CMP_W'(dv_s[j]) << B;
    assign take  = ({DIV_N'(0), dv_rem[j]} >= trial);
    always_ff @(posedge clk) begin
      if (en[ST_DIV+j+1]) begin
        dv_s[j+1]   <= dv_s[j];
        dv_rem[j+1] <= take ? dv_rem[j] - trial[DIV_W-1:0] : dv_rem[j];
        dv_q[j+1]   <= dv_q[j] | (take ? (DIV_N'(1) << B) : '0);
        dv_zr[j+1]  <= dv_zr[j];
        dv_sat[j+1] <= dv_sat[j];
      end
    end
  end

  // output register
  logic [tshc_pkg::TEMP_W-1:0] temp_centi_c;
  tshc_pkg::status_t           status;
  logic [DIV_N-1:0]            ck;

  assign ck = dv_q[DIV_N];

  always_ff @(posedge clk) begin
    if (en[N_ST]) begin
      if (dv_zr[DIV_N]) begin
        temp_centi_c <= '0;
        status       <= tshc_pkg::STATUS_ZERO;
      end else if (dv_sat[DIV_N] || (ck > tshc_pkg::CK_MAX)) begin
        temp_centi_c <= tshc_pkg::TEMP_MAX;
        status       <= tshc_pkg::STATUS_SAT;
      end else begin
        temp_centi_c <= tshc_pkg::TEMP_W'(ck - tshc_pkg::ZERO_C_CENTI);
        status       <= tshc_pkg::STATUS_OK;
      end
    end
  end

  assign m_tvalid = v[N_ST];
  assign m_tdata  = {6'd0, status, temp_centi_c};

`ifndef ASSERT_OFF
  a_zero_temp: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (status == tshc_pkg::STATUS_ZERO) |-> temp_centi_c == '0)
    else $error("zero code result carries a temperature");

  a_sat_temp: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (status == tshc_pkg::STATUS_SAT) |-> temp_centi_c == tshc_pkg::TEMP_MAX)
    else $error("saturated result not at full scale");

  a_ok_floor: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (status == tshc_pkg::STATUS_OK)
      |-> $signed(temp_centi_c) >= -$signed({1'b0, tshc_pkg::ZERO_C_CENTI}))
    else $error("temperature below absolute zero");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  a_ready: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> v[1] && !en[2])
    else $error("input stalled with room in the first stage");
`endif

endmodule
